>>> sv/rwpc_pkg.sv
// Shared types and constants for the rigid wall penalty contact block.
// Used by every module of the block but rwpc_fifo; depends on nothing else.
`default_nettype none

package rwpc_pkg;

    localparam int POS_W        = 21;  // input coordinate field width
    localparam int TAG_W        = 20;
    localparam int D_W          = 22;  // position minus origin
    localparam int N_W          = 21;  // normal component, Q1.19
    localparam int FIELD_STRIDE = 21;
    localparam int CFG_W        = 63;
    localparam int CFG_IDX_W    = 3;
    localparam int SPAN_W       = 42;
    localparam int SCALE_W      = 32;
    localparam int MODE_W       = 3;
    localparam int FORCE_W      = 48;
    localparam int BIDX_W       = 16;

    typedef enum logic [MODE_W-1:0] {
        GEOM_1D_PLANE   = 3'd0,
        GEOM_2D_LINE    = 3'd1,
        GEOM_2D_SEGMENT = 3'd2,
        GEOM_3D_PLANE   = 3'd3,
        GEOM_3D_RECT    = 3'd4
    } t_geom_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN    = 3'd0,
        CFG_NORMAL    = 3'd1,
        CFG_EDGE_A    = 3'd2,
        CFG_EDGE_B    = 3'd3,
        CFG_SPAN_A    = 3'd4,
        CFG_SPAN_B    = 3'd5,
        CFG_STIFFNESS = 3'd6,
        CFG_MODE      = 3'd7
    } t_cfg_index;

    // One classified node, as handed from the front end to the back end.
    typedef struct packed {
        logic signed [D_W-1:0] d_x;
        logic signed [D_W-1:0] d_y;
        logic signed [D_W-1:0] d_z;
        logic                  use_y;
        logic                  use_z;
        logic                  bound_a;
        logic                  bound_b;
        logic                  first;
        logic [TAG_W-1:0]      tag;
    } t_fe_item;

    // Sign-extends a coordinate whose sign sits at bit (bits - 1).
    function automatic logic signed [D_W-1:0] coord_ext(
        input logic [POS_W-1:0] v,
        input int unsigned      bits
    );
        logic signed [D_W-1:0] r;
        r = '0;
        for (int i = 0; i < D_W; i++) begin
            if (i < int'(bits)) begin
                r[i] = v[i];
            end else begin
                r[i] = v[bits-1];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/rigid_wall_penalty_contact_core.sv
// Rigid wall penalty contact: top level with the configuration registers.
// Depends on rwpc_pkg, rwpc_front, rwpc_fifo and rwpc_back.
`default_nettype none

// One node position goes in per beat and one result beat comes out per node,
// in order. With the output taken freely the block sustains one node per
// clock; a node passes the front register and the queue, then five register
// stages in the back end. The FIFO_DEPTH-entry queue between the front and
// back ends absorbs output stalls before the input stalls. Configuration
// writes are always ready and take effect at once; write them only when no
// node is in flight.
module rigid_wall_penalty_contact_core
    import rwpc_pkg::*;
#(
    parameter int MAX_CONTACTS = 65536,
    parameter int COORD_BITS   = 21,
    parameter int FIFO_DEPTH   = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [POS_W-1:0]     i_pos_x,
    input  wire logic [POS_W-1:0]     i_pos_y,
    input  wire logic [POS_W-1:0]     i_pos_z,
    input  wire logic [TAG_W-1:0]     i_node_tag,
    input  wire logic                 i_first_node,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_in_contact,
    output logic [FORCE_W-1:0]        o_force_x,
    output logic [FORCE_W-1:0]        o_force_y,
    output logic [FORCE_W-1:0]        o_force_z,
    output logic [TAG_W-1:0]          o_tag_out,
    output logic [BIDX_W-1:0]         o_block_index,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]   r_origin;
    logic [CFG_W-1:0]   r_normal;
    logic [CFG_W-1:0]   r_edge_a;
    logic [CFG_W-1:0]   r_edge_b;
    logic [SPAN_W-1:0]  r_span_a;
    logic [SPAN_W-1:0]  r_span_b;
    logic [SCALE_W-1:0] r_scale;
    logic [MODE_W-1:0]  r_mode;

    logic     w_q_push;
    logic     w_q_pop;
    logic     w_q_full;
    logic     w_q_empty;
    t_fe_item w_q_in;
    t_fe_item w_q_out;
    logic [$bits(t_fe_item)-1:0] w_q_out_bits;

    assign o_cfg_ready = 1'b1;
    assign w_q_out     = t_fe_item'(w_q_out_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_normal <= '0;
            r_edge_a <= '0;
            r_edge_b <= '0;
            r_span_a <= '0;
            r_span_b <= '0;
            r_scale  <= '0;
            r_mode   <= GEOM_3D_PLANE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ORIGIN:    r_origin <= i_cfg_data;
                CFG_NORMAL:    r_normal <= i_cfg_data;
                CFG_EDGE_A:    r_edge_a <= i_cfg_data;
                CFG_EDGE_B:    r_edge_b <= i_cfg_data;
                CFG_SPAN_A:    r_span_a <= i_cfg_data[SPAN_W-1:0];
                CFG_SPAN_B:    r_span_b <= i_cfg_data[SPAN_W-1:0];
                CFG_STIFFNESS: r_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_MODE:      r_mode   <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rwpc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_node_tag   (i_node_tag),
        .i_first_node (i_first_node),
        .i_origin     (r_origin),
        .i_mode       (r_mode),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_item     (w_q_in)
    );

    rwpc_fifo #(
        .WIDTH ($bits(t_fe_item)),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out_bits),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    rwpc_back #(
        .MAX_CONTACTS (MAX_CONTACTS),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_item      (w_q_out),
        .o_q_pop       (w_q_pop),
        .i_normal      (r_normal),
        .i_edge_a      (r_edge_a),
        .i_edge_b      (r_edge_b),
        .i_span_a      (r_span_a),
        .i_span_b      (r_span_b),
        .i_scale       (r_scale),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_in_contact  (o_in_contact),
        .o_force_x     (o_force_x),
        .o_force_y     (o_force_y),
        .o_force_z     (o_force_z),
        .o_tag_out     (o_tag_out),
        .o_block_index (o_block_index)
    );

endmodule

`default_nettype wire

>>> sv/rwpc_fifo.sv
// Small register queue that decouples the front end from the back end.
// Generic width and depth; no package dependencies.
`default_nettype none

module rwpc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/rwpc_front.sv
// Front end: takes node beats, subtracts the wall origin and decodes the mode.
// Depends on rwpc_pkg; feeds rwpc_fifo.
`default_nettype none

module rwpc_front
    import rwpc_pkg::*;
#(
    parameter int COORD_BITS = 21
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [POS_W-1:0] i_pos_x,
    input  wire logic [POS_W-1:0] i_pos_y,
    input  wire logic [POS_W-1:0] i_pos_z,
    input  wire logic [TAG_W-1:0] i_node_tag,
    input  wire logic             i_first_node,
    input  wire logic [CFG_W-1:0] i_origin,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output t_fe_item              o_q_item
);

    logic     r_vld;
    t_fe_item r_item;
    t_fe_item w_item;
    logic     w_load;

    assign o_in_stall = r_vld && i_q_full;
    assign w_load     = !o_in_stall;
    assign o_q_push   = r_vld && !i_q_full;
    assign o_q_item   = r_item;

    always_comb begin
        logic signed [D_W-1:0] ox;
        logic signed [D_W-1:0] oy;
        logic signed [D_W-1:0] oz;
        ox = coord_ext(i_origin[0*FIELD_STRIDE +: POS_W], COORD_BITS);
        oy = coord_ext(i_origin[1*FIELD_STRIDE +: POS_W], COORD_BITS);
        oz = coord_ext(i_origin[2*FIELD_STRIDE +: POS_W], COORD_BITS);

        w_item.use_y   = 1'b1;
        w_item.use_z   = 1'b1;
        w_item.bound_a = 1'b0;
        w_item.bound_b = 1'b0;
        case (t_geom_mode'(i_mode))
            GEOM_1D_PLANE: begin
                w_item.use_y = 1'b0;
                w_item.use_z = 1'b0;
            end
            GEOM_2D_LINE: begin
                w_item.use_z = 1'b0;
            end
            GEOM_2D_SEGMENT: begin
                w_item.use_z   = 1'b0;
                w_item.bound_a = 1'b1;
            end
            GEOM_3D_RECT: begin
                w_item.bound_a = 1'b1;
                w_item.bound_b = 1'b1;
            end
            default: begin
                // Plain 3D plane, also taken for the unused mode codes.
            end
        endcase

        w_item.d_x = coord_ext(i_pos_x, COORD_BITS) - ox;
        w_item.d_y = w_item.use_y ? coord_ext(i_pos_y, COORD_BITS) - oy : '0;
        w_item.d_z = w_item.use_z ? coord_ext(i_pos_z, COORD_BITS) - oz : '0;
        w_item.first = i_first_node;
        w_item.tag   = i_node_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_item <= w_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/rwpc_back.sv
// Back end: dot products, bounds and contact test, contact count and forces.
// Depends on rwpc_pkg; pulls classified nodes from rwpc_fifo.
`default_nettype none

module rwpc_back
    import rwpc_pkg::*;
#(
    parameter int MAX_CONTACTS = 65536,
    parameter int COORD_BITS   = 21
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire t_fe_item           i_q_item,
    output logic                    o_q_pop,
    input  wire logic [CFG_W-1:0]   i_normal,
    input  wire logic [CFG_W-1:0]   i_edge_a,
    input  wire logic [CFG_W-1:0]   i_edge_b,
    input  wire logic [SPAN_W-1:0]  i_span_a,
    input  wire logic [SPAN_W-1:0]  i_span_b,
    input  wire logic [SCALE_W-1:0] i_scale,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_in_contact,
    output logic [FORCE_W-1:0]      o_force_x,
    output logic [FORCE_W-1:0]      o_force_y,
    output logic [FORCE_W-1:0]      o_force_z,
    output logic [TAG_W-1:0]        o_tag_out,
    output logic [BIDX_W-1:0]       o_block_index
);

    localparam int PW  = 2 * D_W;          // one product of the dot products
    localparam int SW  = PW + 2;           // sum of three products
    localparam int P16 = SW - 13;          // penetration with 16 fraction bits
    localparam int TPW = P16 + N_W;        // penetration times normal
    localparam int T_W = 32;               // t fits 32 signed bits by range
    localparam int FPW = T_W + SCALE_W + 1;
    localparam int FW  = FPW - 16;
    localparam int CW  = $clog2(MAX_CONTACTS + 1);
    localparam int BW  = (CW > BIDX_W + 1) ? CW : BIDX_W + 1;

    logic w_adv;

    logic signed [N_W-1:0] w_n  [3];
    logic signed [D_W-1:0] w_ea [3];
    logic signed [D_W-1:0] w_eb [3];
    logic signed [D_W-1:0] w_d  [3];

    // Stage 1: products.
    logic                  r_s1_vld;
    logic signed [PW-1:0]  r_pn [3];
    logic signed [PW-1:0]  r_pa [3];
    logic signed [PW-1:0]  r_pb [3];
    logic                  r_s1_use_y, r_s1_use_z, r_s1_ba, r_s1_bb, r_s1_first;
    logic [TAG_W-1:0]      r_s1_tag;

    // Stage 2: sums.
    logic                  r_s2_vld;
    logic signed [SW-1:0]  r_pen, r_proj_a, r_proj_b;
    logic                  r_s2_use_y, r_s2_use_z, r_s2_ba, r_s2_bb, r_s2_first;
    logic [TAG_W-1:0]      r_s2_tag;

    // Stage 3: contact test, count, penetration times normal.
    logic                  r_s3_vld;
    logic signed [TPW-1:0] r_tp [3];
    logic                  r_s3_hit, r_s3_use_y, r_s3_use_z;
    logic [TAG_W-1:0]      r_s3_tag;
    logic [BIDX_W-1:0]     r_s3_bidx;
    logic [CW-1:0]         r_count;

    // Stage 4: times stiffness.
    logic                  r_s4_vld;
    logic signed [FPW-1:0] r_fp [3];
    logic                  r_s4_hit, r_s4_use_y, r_s4_use_z;
    logic [TAG_W-1:0]      r_s4_tag;
    logic [BIDX_W-1:0]     r_s4_bidx;

    // Output register.
    logic                  r_out_vld;
    logic                  r_out_hit;
    logic [FORCE_W-1:0]    r_f [3];
    logic [TAG_W-1:0]      r_out_tag;
    logic [BIDX_W-1:0]     r_out_bidx;

    logic                  w_hit;
    logic [CW-1:0]         w_before;
    logic [BW-1:0]         w_before_w;
    logic [BIDX_W-1:0]     w_bidx;
    logic signed [P16-1:0] w_pen16;
    logic [FORCE_W-1:0]    w_f [3];
    logic                  w_keep [3];

    assign w_adv   = !r_out_vld || !i_out_stall;
    assign o_q_pop = w_adv && !i_q_empty;

    always_comb begin
        w_d[0] = i_q_item.d_x;
        w_d[1] = i_q_item.d_y;
        w_d[2] = i_q_item.d_z;
        for (int k = 0; k < 3; k++) begin
            w_n[k]  = i_normal[k*FIELD_STRIDE +: N_W];
            w_ea[k] = coord_ext(i_edge_a[k*FIELD_STRIDE +: POS_W], COORD_BITS);
            w_eb[k] = coord_ext(i_edge_b[k*FIELD_STRIDE +: POS_W], COORD_BITS);
        end
    end

    // Contact test and the running count, for the item moving into stage 3.
    always_comb begin
        logic ok_a;
        logic ok_b;
        ok_a = !r_proj_a[SW-1] && (r_proj_a[SW-2:0] <= (SW-1)'(i_span_a));
        ok_b = !r_proj_b[SW-1] && (r_proj_b[SW-2:0] <= (SW-1)'(i_span_b));
        w_hit = (!r_s2_ba || ok_a) && (!r_s2_bb || ok_b) && (r_pen <= 0);
        w_before   = r_s2_first ? '0 : r_count;
        w_before_w = BW'(w_before);
        w_bidx     = (w_before_w > BW'({BIDX_W{1'b1}})) ? {BIDX_W{1'b1}}
                                                        : w_before_w[BIDX_W-1:0];
        // Arithmetic shift right by 13 is a floor.
        w_pen16 = r_pen[SW-1:13];
    end

    always_comb begin
        w_keep[0] = r_s4_hit;
        w_keep[1] = r_s4_hit && r_s4_use_y;
        w_keep[2] = r_s4_hit && r_s4_use_z;
        for (int k = 0; k < 3; k++) begin
            logic signed [FW-1:0] f;
            f = r_fp[k][FPW-1:16];
            if (!w_keep[k]) begin
                w_f[k] = '0;
            end else if (f[FW-1] != f[FW-2] || f[FW-2] != f[FORCE_W-1]) begin
                w_f[k] = f[FW-1] ? {1'b1, {(FORCE_W-1){1'b0}}}
                                 : {1'b0, {(FORCE_W-1){1'b1}}};
            end else begin
                w_f[k] = f[FORCE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= '0;
        end else if (w_adv) begin
            r_s1_vld  <= !i_q_empty;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
            if (r_s2_vld) begin
                r_count <= (w_hit && (w_before < CW'(MAX_CONTACTS))) ? w_before + 1'b1
                                                                     : w_before;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_pn[k] <= w_d[k] * w_n[k];
                r_pa[k] <= w_d[k] * w_ea[k];
                r_pb[k] <= w_d[k] * w_eb[k];
            end
            r_s1_use_y <= i_q_item.use_y;
            r_s1_use_z <= i_q_item.use_z;
            r_s1_ba    <= i_q_item.bound_a;
            r_s1_bb    <= i_q_item.bound_b;
            r_s1_first <= i_q_item.first;
            r_s1_tag   <= i_q_item.tag;

            r_pen      <= SW'(r_pn[0]) + SW'(r_pn[1]) + SW'(r_pn[2]);
            r_proj_a   <= SW'(r_pa[0]) + SW'(r_pa[1]) + SW'(r_pa[2]);
            r_proj_b   <= SW'(r_pb[0]) + SW'(r_pb[1]) + SW'(r_pb[2]);
            r_s2_use_y <= r_s1_use_y;
            r_s2_use_z <= r_s1_use_z;
            r_s2_ba    <= r_s1_ba;
            r_s2_bb    <= r_s1_bb;
            r_s2_first <= r_s1_first;
            r_s2_tag   <= r_s1_tag;

            for (int k = 0; k < 3; k++) begin
                r_tp[k] <= w_pen16 * w_n[k];
            end
            r_s3_hit   <= w_hit;
            r_s3_use_y <= r_s2_use_y;
            r_s3_use_z <= r_s2_use_z;
            r_s3_tag   <= r_s2_tag;
            r_s3_bidx  <= w_bidx;

            // t is the floor of the product over 2^19; its range fits 32 bits.
            for (int k = 0; k < 3; k++) begin
                r_fp[k] <= $signed(r_tp[k][19 +: T_W]) * $signed({1'b0, i_scale});
            end
            r_s4_hit   <= r_s3_hit;
            r_s4_use_y <= r_s3_use_y;
            r_s4_use_z <= r_s3_use_z;
            r_s4_tag   <= r_s3_tag;
            r_s4_bidx  <= r_s3_bidx;

            r_out_hit  <= r_s4_hit;
            for (int k = 0; k < 3; k++) begin
                r_f[k] <= w_f[k];
            end
            r_out_tag  <= r_s4_tag;
            r_out_bidx <= r_s4_bidx;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_in_contact  = r_out_hit;
    assign o_force_x     = r_f[0];
    assign o_force_y     = r_f[1];
    assign o_force_z     = r_f[2];
    assign o_tag_out     = r_out_tag;
    assign o_block_index = r_out_bidx;

endmodule

`default_nettype wire

>>> sv/rwpc_checker.sv
// Port-level checks for the rigid wall penalty contact block, and their bind.
// Depends on rwpc_pkg and on the top level rigid_wall_penalty_contact_core.
`default_nettype none

module rwpc_checker
    import rwpc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic               o_in_contact,
    input wire logic [FORCE_W-1:0] o_force_x,
    input wire logic [FORCE_W-1:0] o_force_y,
    input wire logic [FORCE_W-1:0] o_force_z,
    input wire logic [TAG_W-1:0]   o_tag_out,
    input wire logic [BIDX_W-1:0]  o_block_index
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_in_contact)
            && $stable(o_force_x) && $stable(o_force_y) && $stable(o_force_z)
            && $stable(o_tag_out) && $stable(o_block_index))
        else $error("result beat changed while stalled");

    // A node that is not in contact carries no force.
    a_no_contact_no_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_contact |->
            (o_force_x == '0) && (o_force_y == '0) && (o_force_z == '0))
        else $error("force given without contact");

    // Reset empties both the front register and the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind rigid_wall_penalty_contact_core rwpc_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_in_contact  (o_in_contact),
    .o_force_x     (o_force_x),
    .o_force_y     (o_force_y),
    .o_force_z     (o_force_z),
    .o_tag_out     (o_tag_out),
    .o_block_index (o_block_index)
);

`default_nettype wire
